/* hw/rtl/ipra_pkg.sv */
// Package for the I/O port range allocator.
// Holds pool sizing, port constants, codes, entry type and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package ipra_pkg;

  localparam int POOL_ENTRIES = 32;
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

  localparam logic [16:0] SEARCH_BASE = 17'h00400;
  localparam logic [17:0] PORT_SPACE  = 18'h10000;
  localparam logic [15:0] VGA_A_LO    = 16'h02b0;
  localparam logic [17:0] VGA_A_HI    = 18'h002e0;
  localparam logic [15:0] VGA_B_LO    = 16'h03c0;
  localparam logic [17:0] VGA_B_HI    = 18'h003db;

  localparam logic [2:0] OP_CLAIM_FIXED = 3'd0;
  localparam logic [2:0] OP_CLAIM_ANY   = 3'd1;
  localparam logic [2:0] OP_RESERVE_ANY = 3'd2;
  localparam logic [2:0] OP_RELEASE     = 3'd3;
  localparam logic [2:0] OP_CHECK       = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CLASH  = 2'd1,
    ST_FULL   = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_EVAL,
    S_MOD,
    S_INS_RD,
    S_INS_MV,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_MV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] start;
    logic [16:0] stop;
    logic        rsv;
  } span_t;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    rd_prev;
    logic    k_inc;
    logic    k_dec;
    logic    k_from_used;
    logic    at_from_k;
    logic    cand_upd;
    logic    mod_start;
    logic    wr_take;
    logic    wr_up;
    logic    wr_down;
    logic    wr_new;
    logic    used_dec;
    logic    cap_fixed;
    logic    cap_search;
    logic    set_st;
    status_t st_val;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       k_at_used;
    logic       k_eq_at;
    logic       pool_full;
    logic       lim_over;
    logic       vga_ok;
    logic       e_below;
    logic       e_take;
    logic       e_after;
    logic       s_low;
    logic       s_gap;
    logic       s_eq_port;
    logic       s_gt_port;
    logic       overlap;
    logic       align_zero;
    logic       mod_busy;
  } sts_t;

endpackage

/* hw/rtl/ipra_ifs.sv */
// Request and response channel interfaces of the port range allocator.
// Depends on nothing; payload widths follow the request and response fields.
`timescale 1ns / 1ps

interface ipra_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] port;
  logic [16:0] range_size;
  logic [15:0] alignment;
  modport source (output valid, opcode, port, range_size, alignment, input ready);
  modport sink (input valid, opcode, port, range_size, alignment, output ready);
endinterface

interface ipra_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_port;
  logic        took_reservation;
  modport source (output valid, status, granted_port, took_reservation, input ready);
  modport sink (input valid, status, granted_port, took_reservation, output ready);
endinterface

/* hw/rtl/ipra_ctrl.sv */
// Controller state machine of the port range allocator.
// Depends on ipra_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module ipra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  ipra_pkg::sts_t sts,
  output ipra_pkg::cmd_t cmd
);
  import ipra_pkg::*;

  state_t state, state_next;
  logic   out_free;
  logic   is_search;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign is_search = (sts.op == OP_CLAIM_ANY) || (sts.op == OP_RESERVE_ANY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.op == OP_CLAIM_FIXED) begin
          state_next = sts.lim_over ? S_FIN : S_READ;
        end else if (is_search || sts.op == OP_RELEASE) begin
          state_next = S_READ;
        end else if (sts.op == OP_CHECK) begin
          state_next = sts.vga_ok ? S_FIN : S_READ;
        end else begin
          state_next = S_FIN;
        end
      end
      S_READ: begin
        if (!sts.k_at_used) begin
          state_next = S_EVAL;
        end else if (sts.op == OP_CLAIM_FIXED && !sts.pool_full) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_EVAL: begin
        if (sts.op == OP_CLAIM_FIXED) begin
          if (sts.e_below) state_next = S_READ;
          else if (sts.e_take) state_next = S_FIN;
          else if (sts.e_after && !sts.pool_full) state_next = S_INS_RD;
          else state_next = S_FIN;
        end else if (is_search) begin
          if (sts.s_low) state_next = S_READ;
          else if (sts.s_gap) state_next = sts.pool_full ? S_FIN : S_INS_RD;
          else if (sts.align_zero) state_next = S_READ;
          else state_next = S_MOD;
        end else if (sts.op == OP_RELEASE) begin
          if (sts.s_eq_port) state_next = S_DEL_RD;
          else if (sts.s_gt_port) state_next = S_FIN;
          else state_next = S_READ;
        end else begin
          state_next = sts.overlap ? S_FIN : S_READ;
        end
      end
      S_MOD: begin
        if (!sts.mod_busy) state_next = S_READ;
      end
      S_INS_RD: begin
        state_next = sts.k_eq_at ? S_INS_WR : S_INS_MV;
      end
      S_INS_MV: begin
        state_next = S_INS_RD;
      end
      S_INS_WR: begin
        state_next = S_FIN;
      end
      S_DEL_RD: begin
        state_next = sts.k_at_used ? S_FIN : S_DEL_MV;
      end
      S_DEL_MV: begin
        state_next = S_DEL_RD;
      end
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = req_valid;
      end
      S_DISPATCH: begin
        if (sts.op == OP_CLAIM_FIXED) begin
          if (sts.lim_over) begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_CLASH;
          end
        end else if (!is_search && sts.op != OP_RELEASE && sts.op != OP_CHECK) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_CLASH;
        end
      end
      S_READ: begin
        if (!sts.k_at_used) begin
          cmd.rd = 1'b1;
        end else if (sts.op == OP_CLAIM_FIXED) begin
          cmd.cap_fixed = 1'b1;
          cmd.k_from_used = 1'b1;
          if (sts.pool_full) begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_FULL;
          end
        end else if (is_search) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_CLASH;
        end
      end
      S_EVAL: begin
        if (sts.op == OP_CLAIM_FIXED) begin
          if (sts.e_below) begin
            cmd.k_inc = 1'b1;
          end else if (sts.e_take) begin
            cmd.wr_take = 1'b1;
          end else if (sts.e_after) begin
            cmd.at_from_k   = 1'b1;
            cmd.cap_fixed   = 1'b1;
            cmd.k_from_used = 1'b1;
            if (sts.pool_full) begin
              cmd.set_st = 1'b1;
              cmd.st_val = ST_FULL;
            end
          end else begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_CLASH;
          end
        end else if (is_search) begin
          if (sts.s_low) begin
            cmd.k_inc = 1'b1;
          end else if (sts.s_gap) begin
            cmd.at_from_k   = 1'b1;
            cmd.cap_search  = 1'b1;
            cmd.k_from_used = 1'b1;
            if (sts.pool_full) begin
              cmd.set_st = 1'b1;
              cmd.st_val = ST_FULL;
            end
          end else if (sts.align_zero) begin
            cmd.cand_upd = 1'b1;
            cmd.k_inc    = 1'b1;
          end else begin
            cmd.mod_start = 1'b1;
          end
        end else if (sts.op == OP_RELEASE) begin
          if (sts.s_eq_port || !sts.s_gt_port) cmd.k_inc = 1'b1;
        end else begin
          if (sts.overlap) begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_DENIED;
          end else begin
            cmd.k_inc = 1'b1;
          end
        end
      end
      S_MOD: begin
        if (!sts.mod_busy) begin
          cmd.cand_upd = 1'b1;
          cmd.k_inc    = 1'b1;
        end
      end
      S_INS_RD: begin
        if (!sts.k_eq_at) begin
          cmd.rd      = 1'b1;
          cmd.rd_prev = 1'b1;
        end
      end
      S_INS_MV: begin
        cmd.wr_up = 1'b1;
        cmd.k_dec = 1'b1;
      end
      S_INS_WR: begin
        cmd.wr_new = 1'b1;
      end
      S_DEL_RD: begin
        if (sts.k_at_used) cmd.used_dec = 1'b1;
        else cmd.rd = 1'b1;
      end
      S_DEL_MV: begin
        cmd.wr_down = 1'b1;
        cmd.k_inc   = 1'b1;
      end
      S_FIN: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/ipra_dp.sv */
// Datapath of the port range allocator: range table memory, walk index,
// search candidate, alignment remainder unit and result registers. Uses ipra_pkg.
`timescale 1ns / 1ps

module ipra_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ipra_pkg::cmd_t       cmd,
  output ipra_pkg::sts_t       sts,
  input  logic [2:0]           opcode,
  input  logic [15:0]          port,
  input  logic [16:0]          range_size,
  input  logic [15:0]          alignment,
  output logic [1:0]           status,
  output logic [15:0]          granted_port,
  output logic                 took_reservation
);
  import ipra_pkg::*;

  span_t       mem [POOL_ENTRIES];
  span_t       rdata;
  span_t       new_ent;
  logic [2:0]  op;
  logic [15:0] port_r;
  logic [16:0] size_r;
  logic [15:0] align_r;
  logic [17:0] lim;
  logic [16:0] cand;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] at;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] k_prev;
  status_t     st;
  logic [15:0] granted;
  logic        took;
  logic [15:0] rem;
  logic [4:0]  mod_cnt;
  logic        mod_busy;
  logic [16:0] mod_t;
  logic [16:0] cand_next;
  logic [17:0] cand_lim;
  logic [IDX_W-1:0] wr_addr;
  span_t       wr_data;
  logic        wr_en;

  assign k_prev   = k - CNT_W'(1);
  assign cand_lim = {1'b0, cand} + {1'b0, size_r};
  assign mod_t    = {rem, rdata.stop[mod_cnt]};

  always_comb begin
    if (align_r == 16'd0 || rem == 16'd0) begin
      cand_next = rdata.stop;
    end else begin
      cand_next = rdata.stop + {1'b0, align_r - rem};
    end
  end

  always_comb begin
    sts.op         = op;
    sts.k_at_used  = (k == used);
    sts.k_eq_at    = (k == at);
    sts.pool_full  = (used == CNT_W'(POOL_ENTRIES));
    sts.lim_over   = (lim > PORT_SPACE);
    sts.vga_ok     = (port_r >= VGA_A_LO && lim <= VGA_A_HI) ||
                     (port_r >= VGA_B_LO && lim <= VGA_B_HI);
    sts.e_below    = (rdata.stop <= {1'b0, port_r});
    sts.e_take     = rdata.rsv && (rdata.start == port_r) && ({1'b0, rdata.stop} >= lim);
    sts.e_after    = ({2'b0, rdata.start} >= lim);
    sts.s_low      = ({1'b0, rdata.start} < SEARCH_BASE);
    sts.s_gap      = ({2'b0, rdata.start} > cand_lim);
    sts.s_eq_port  = (rdata.start == port_r);
    sts.s_gt_port  = (rdata.start > port_r);
    sts.overlap    = (port_r >= rdata.start && {1'b0, port_r} < rdata.stop) ||
                     (port_r <= rdata.start && lim > {2'b0, rdata.start});
    sts.align_zero = (align_r == 16'd0);
    sts.mod_busy   = mod_busy;
  end

  always_comb begin
    wr_en   = cmd.wr_take || cmd.wr_up || cmd.wr_down || cmd.wr_new;
    wr_addr = k[IDX_W-1:0];
    wr_data = rdata;
    if (cmd.wr_take) begin
      wr_data.rsv = 1'b0;
    end else if (cmd.wr_down) begin
      wr_addr = k_prev[IDX_W-1:0];
    end else if (cmd.wr_new) begin
      wr_addr = at[IDX_W-1:0];
      wr_data = new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rdata <= mem[cmd.rd_prev ? k_prev[IDX_W-1:0] : k[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      mod_busy <= 1'b0;
    end else begin
      if (cmd.wr_new) used <= used + CNT_W'(1);
      else if (cmd.used_dec) used <= used - CNT_W'(1);
      if (cmd.mod_start) begin
        mod_busy <= 1'b1;
      end else if (mod_busy && mod_cnt == 5'd0) begin
        mod_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= opcode;
      port_r  <= port;
      size_r  <= range_size;
      align_r <= alignment;
      lim     <= {2'b0, port} + {1'b0, range_size};
      k       <= '0;
      at      <= used;
      cand    <= SEARCH_BASE;
      st      <= ST_OK;
      granted <= 16'd0;
      took    <= 1'b0;
    end else begin
      if (cmd.k_from_used) k <= used;
      else if (cmd.k_inc) k <= k + CNT_W'(1);
      else if (cmd.k_dec) k <= k_prev;
      if (cmd.at_from_k) at <= k;
      if (cmd.cand_upd) cand <= cand_next;
      if (cmd.set_st) st <= cmd.st_val;
      if (cmd.wr_take) begin
        granted <= rdata.start;
        took    <= 1'b1;
      end
      if (cmd.cap_fixed) begin
        granted <= port_r;
        new_ent <= '{start: port_r, stop: lim[16:0], rsv: 1'b0};
      end
      if (cmd.cap_search) begin
        granted <= cand[15:0];
        new_ent <= '{start: cand[15:0], stop: cand_lim[16:0], rsv: (op == OP_RESERVE_ANY)};
      end
    end
    if (cmd.mod_start) begin
      rem     <= 16'd0;
      mod_cnt <= 5'd16;
    end else if (mod_busy) begin
      rem     <= (mod_t >= {1'b0, align_r}) ? 16'(mod_t - {1'b0, align_r}) : mod_t[15:0];
      mod_cnt <= mod_cnt - 5'd1;
    end
    if (cmd.out_load) begin
      status           <= st;
      granted_port     <= granted;
      took_reservation <= took;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(POOL_ENTRIES)) else $error("entry count past pool size");
  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> used != CNT_W'(POOL_ENTRIES)) else $error("insert into full pool");
  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> align_r != 16'd0) else $error("rounding with zero alignment");

endmodule

/* hw/rtl/io_port_range_allocator_unit.sv */
// Top level of the I/O port range allocator.
// Depends on ipra_pkg, ipra_ifs, ipra_ctrl and ipra_dp.
//
//   channel  modport  payload
//   req      sink     opcode, port, range_size, alignment
//   rsp      source   status, granted_port, took_reservation
//
// One request at a time. Each request walks the sorted table entry by entry, reading
// an entry in S_READ and judging it in S_EVAL; the walk may stop early or be skipped.
// With a nonzero alignment each entry stepped over in a search runs the bit-serial
// remainder in S_MOD; an insert moves each entry above the new one up by one slot,
// and a release moves each entry above the removed one down by one slot.
// The table memory has a write port and a registered read port.
// Reset empties the table at once. A stalled response holds; a new request is
// taken while the previous response still waits.
`timescale 1ns / 1ps

module io_port_range_allocator_unit (
  input logic       clk,
  input logic       rst,
  ipra_req_if.sink  req,
  ipra_rsp_if.source rsp
);
  import ipra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ipra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ipra_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .opcode           (req.opcode),
    .port             (req.port),
    .range_size       (req.range_size),
    .alignment        (req.alignment),
    .status           (rsp.status),
    .granted_port     (rsp.granted_port),
    .took_reservation (rsp.took_reservation)
  );

endmodule

/* tb/io_port_range_allocator_unit_tb.sv */
// Testbench for the I/O port range allocator: directed and random requests
// checked against an in-bench model of the sorted range table.
// Depends on ipra_pkg, ipra_ifs and io_port_range_allocator_unit.
`timescale 1ns / 1ps

module io_port_range_allocator_unit_tb;
  import ipra_pkg::*;

  localparam int MAX_IDLE = 200000;

  typedef struct {
    logic [2:0]  opcode;
    logic [15:0] port;
    logic [16:0] range_size;
    logic [15:0] alignment;
  } request_t;

  typedef struct {
    status_t     status;
    logic [15:0] granted_port;
    logic        took_reservation;
  } answer_t;

  typedef struct {
    int unsigned start;
    int unsigned stop;
    bit          rsv;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   idle_cycles = 0;
  bit   in_hold_off = 1'b0;
  answer_t answers_due[$];
  entry_t  ranges[$];

  ipra_req_if req ();
  ipra_rsp_if rsp ();

  io_port_range_allocator_unit i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.opcode = '0;
    req.port = '0;
    req.range_size = '0;
    req.alignment = '0;
    rsp.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int unsigned pick_gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic answer_t allocate_ports(request_t q);
    answer_t a;
    int unsigned port, size, lim, cand, al, at, k;
    bit done, ok, found;
    port = q.port;
    size = q.range_size;
    al = q.alignment;
    lim = port + size;
    a.status = ST_OK;
    a.granted_port = '0;
    a.took_reservation = 1'b0;
    case (q.opcode)
      OP_CLAIM_FIXED: begin
        if (lim > 32'h10000) begin
          a.status = ST_CLASH;
        end else begin
          done = 0;
          at = ranges.size();
          for (k = 0; k < ranges.size(); k++) begin
            if (ranges[k].stop <= port) continue;
            if (ranges[k].rsv && ranges[k].start == port && ranges[k].stop >= lim) begin
              ranges[k].rsv = 0;
              a.granted_port = port;
              a.took_reservation = 1'b1;
              done = 1;
              break;
            end
            if (ranges[k].start >= lim) begin
              at = k;
              break;
            end
            a.status = ST_CLASH;
            done = 1;
            break;
          end
          if (!done) begin
            a.granted_port = port;
            if (ranges.size() >= POOL_ENTRIES) a.status = ST_FULL;
            else ranges.insert(at, '{port, lim, 1'b0});
          end
        end
      end
      OP_CLAIM_ANY, OP_RESERVE_ANY: begin
        cand = 32'h400;
        found = 0;
        for (k = 0; k < ranges.size(); k++) begin
          if (ranges[k].start < 32'h400) continue;
          if (ranges[k].start > cand + size) begin
            at = k;
            found = 1;
            break;
          end
          if (al != 0) cand = ((ranges[k].stop + al - 1) / al) * al;
          else cand = ranges[k].stop;
        end
        if (!found) begin
          a.status = ST_CLASH;
        end else begin
          a.granted_port = cand[15:0];
          if (ranges.size() >= POOL_ENTRIES) a.status = ST_FULL;
          else ranges.insert(at, '{cand, cand + size, q.opcode == OP_RESERVE_ANY});
        end
      end
      OP_RELEASE: begin
        for (k = 0; k < ranges.size(); k++) begin
          if (ranges[k].start == port) begin
            ranges.delete(k);
            break;
          end
          if (ranges[k].start > port) break;
        end
      end
      OP_CHECK: begin
        if (port >= 32'h2b0 && lim <= 32'h2e0) ok = 1;
        else if (port >= 32'h3c0 && lim <= 32'h3db) ok = 1;
        else begin
          ok = 1;
          foreach (ranges[k])
            if ((port >= ranges[k].start && port < ranges[k].stop) ||
                (port <= ranges[k].start && lim > ranges[k].start)) ok = 0;
        end
        if (!ok) a.status = ST_DENIED;
      end
      default: a.status = ST_CLASH;
    endcase
    return a;
  endfunction

  task automatic send_request(input logic [2:0] op, input int unsigned port,
                              input int unsigned size, input int unsigned al);
    request_t q;
    int unsigned gap;
    gap = pick_gap_len();
    repeat (gap + 1) @(posedge clk);
    q.opcode = op;
    q.port = port[15:0];
    q.range_size = size[16:0];
    q.alignment = al[15:0];
    req.valid <= 1'b1;
    req.opcode <= q.opcode;
    req.port <= q.port;
    req.range_size <= q.range_size;
    req.alignment <= q.alignment;
    do @(posedge clk); while (!req.ready);
    answers_due.push_back(allocate_ports(q));
    req.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic clear_table();
    wait_drained();
    while (ranges.size() != 0) send_request(OP_RELEASE, ranges[0].start, 0, 0);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst) rsp.ready <= !in_hold_off && ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected transfer", rsp.status, 0);
      end else begin
        want = answers_due.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", rsp.status, want.status);
        if (rsp.granted_port !== want.granted_port)
          report_mismatch("granted_port", rsp.granted_port, want.granted_port);
        if (rsp.took_reservation !== want.took_reservation)
          report_mismatch("took_reservation", rsp.took_reservation, want.took_reservation);
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > MAX_IDLE) begin
      $display("io_port_range_allocator_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic test_fixed_claims();
    send_request(OP_CLAIM_FIXED, 16'h0000, 17'h00010, 0);
    send_request(OP_CLAIM_FIXED, 16'h0008, 17'h00004, 0);
    send_request(OP_CLAIM_FIXED, 16'hffff, 17'h00001, 0);
    send_request(OP_CLAIM_FIXED, 16'hffff, 17'h00002, 0);
    send_request(OP_CLAIM_FIXED, 16'h0000, 17'h10000, 0);
    send_request(OP_CLAIM_FIXED, 16'h0100, 17'h00000, 0);
    send_request(OP_CLAIM_FIXED, 16'h0800, 17'h00020, 0);
  endtask

  task automatic test_searches();
    send_request(OP_CLAIM_ANY, 0, 16'h0010, 0);
    send_request(OP_RESERVE_ANY, 0, 16'h0008, 0);
    send_request(OP_RESERVE_ANY, 0, 16'h0010, 16'h0100);
    send_request(OP_CLAIM_ANY, 0, 16'h0005, 16'hffff);
    send_request(OP_CLAIM_ANY, 0, 17'h10000, 0);
  endtask

  task automatic test_takeover();
    wait_drained();
    foreach (ranges[k])
      if (ranges[k].rsv) begin
        send_request(OP_CLAIM_FIXED, ranges[k].start, ranges[k].stop - ranges[k].start, 0);
        break;
      end
    send_request(OP_CLAIM_FIXED, 16'h0800, 17'h00010, 0);
  endtask

  task automatic test_release_and_check();
    send_request(OP_RELEASE, 16'h0008, 0, 0);
    send_request(OP_RELEASE, 16'h0000, 0, 0);
    send_request(OP_CHECK, 16'h02b0, 17'h00030, 0);
    send_request(OP_CHECK, 16'h03c0, 17'h0001b, 0);
    send_request(OP_CHECK, 16'h03c0, 17'h0001c, 0);
    send_request(OP_CHECK, 16'h0800, 17'h00000, 0);
    send_request(OP_CHECK, 16'h07f0, 17'h1ffff, 0);
    send_request(3'd5, 16'hffff, 17'h1ffff, 16'hffff);
    send_request(3'd7, 0, 0, 0);
  endtask

  task automatic test_pool_full();
    int i;
    clear_table();
    for (i = 0; i < POOL_ENTRIES + 2; i++)
      send_request(OP_CLAIM_FIXED, 16'h1000 + i * 16, 16, 0);
    send_request(OP_CLAIM_ANY, 0, 4, 0);
    in_hold_off = 1'b1;
    repeat (30) @(posedge clk);
    in_hold_off = 1'b0;
    wait_drained();
    clear_table();
  endtask

  task automatic test_random(input int count);
    int i;
    int unsigned r, op, port, size, al;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = $urandom_range(5, 7);
      else if (r < 30) op = OP_CLAIM_FIXED;
      else if (r < 45) op = OP_CLAIM_ANY;
      else if (r < 55) op = OP_RESERVE_ANY;
      else if (r < 75) op = OP_RELEASE;
      else op = OP_CHECK;
      r = $urandom_range(0, 9);
      if (r < 6) port = $urandom_range(16'h0200, 16'h2000);
      else port = $urandom();
      r = $urandom_range(0, 19);
      if (r == 0) size = $urandom_range(0, 17'h1ffff);
      else if (r < 3) size = $urandom_range(0, 16'hffff);
      else size = $urandom_range(0, 64);
      r = $urandom_range(0, 9);
      if (r < 5) al = 0;
      else if (r < 9) al = 1 << $urandom_range(0, 8);
      else al = $urandom_range(0, 16'hffff);
      if (op == OP_RELEASE && ranges.size() != 0 && $urandom_range(0, 3) != 0)
        port = ranges[$urandom_range(0, ranges.size() - 1)].start;
      else if (op == OP_CLAIM_FIXED && ranges.size() != 0 && $urandom_range(0, 4) == 0) begin
        wait_drained();
        r = $urandom_range(0, ranges.size() - 1);
        port = ranges[r].start;
        size = ranges[r].stop - port - $urandom_range(0, 1);
        if (ranges[r].stop == port) size = 0;
      end
      if (op == OP_CLAIM_ANY || op == OP_RESERVE_ANY) begin
        if (ranges.size() == 0 || ranges[ranges.size() - 1].start < 16'h0400)
          send_request(OP_CLAIM_FIXED, 16'hf000 + $urandom_range(0, 16'h0fff), 1, 0);
      end
      send_request(op[2:0], port, size, al);
      if (i % 400 == 399) clear_table();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fixed_claims();
    test_searches();
    test_takeover();
    test_release_and_check();
    test_pool_full();
    test_random(1900);
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("io_port_range_allocator_unit_tb: PASS");
    else $display("io_port_range_allocator_unit_tb: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ipra_pkg.sv
hw/rtl/ipra_ifs.sv
hw/rtl/ipra_ctrl.sv
hw/rtl/ipra_dp.sv
hw/rtl/io_port_range_allocator_unit.sv
tb/io_port_range_allocator_unit_tb.sv
